@@ hw/rtl/pva_pkg.sv @@
// Package for the polyphonic voice allocator.
// Holds the command codes, the scan states, the voice entry layout and the word types.
// No dependencies.
package pva_pkg;

   localparam int DefaultVoices = 8;
   localparam int LevelScale = 516;
   localparam logic [31:0] TimeStart = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_NOTE_ON    = 2'd0,
      CMD_NOTE_OFF   = 2'd1,
      CMD_ALL_OFF    = 2'd2,
      CMD_VOICE_DONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_COMMIT,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic        released;
      logic [31:0] rel_time;
      logic [6:0]  pitch;
      logic        env_idle;
   } voice_entry_type;

   localparam voice_entry_type ResetEntry = '{
      released: 1'b1, rel_time: 32'd0, pitch: 7'd0, env_idle: 1'b1};

   typedef struct packed {
      logic [1:0]  command;
      logic [6:0]  pitch;
      logic [6:0]  velocity;
      logic [2:0]  done_voice;
      logic [31:0] now;
   } req_word_type;

   typedef struct packed {
      logic        assigned;
      logic [2:0]  voice;
      logic [15:0] level;
      logic [7:0]  released_mask;
   } rsp_word_type;

   typedef struct packed {
      logic ready;
      logic load;
   } scan_status_type;

endpackage

@@ hw/rtl/pva_req_if.sv @@
// Request channel of the voice allocator: valid, ready and one event word.
// No dependencies.
interface pva_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [6:0]  pitch;
   logic [6:0]  velocity;
   logic [2:0]  done_voice;
   logic [31:0] now;

   modport source (output valid, command, pitch, velocity, done_voice, now, input ready);
   modport sink (input valid, command, pitch, velocity, done_voice, now, output ready);
endinterface

@@ hw/rtl/pva_rsp_if.sv @@
// Response channel of the voice allocator: valid, ready and one result word.
// No dependencies.
interface pva_rsp_if;
   logic        valid;
   logic        ready;
   logic        assigned;
   logic [2:0]  voice;
   logic [15:0] level;
   logic [7:0]  released_mask;

   modport source (output valid, assigned, voice, level, released_mask, input ready);
   modport sink (input valid, assigned, voice, level, released_mask, output ready);
endinterface

@@ hw/rtl/polyphonic_voice_allocator.sv @@
// Polyphonic voice allocator: top level with the request and response channels.
// Depends on pva_pkg, pva_req_if, pva_rsp_if and pva_voice_scan.
//
// Each request word carries one event: note on, note off, all notes off or
// voice envelope finished. Every request yields exactly one response word.
// A note on reports whether a voice was found, the voice index and the trigger
// level; note off and all notes off report the voices they released.
// The voice table sits in a RAM with one entry per voice, read one entry per
// cycle. A word is applied by one walk over the voice RAM through the scan,
// last and commit states, and its response is then loaded into the output
// register; a new word is accepted only once the previous walk has finished
// and its response has been loaded, so words do not overlap in the scanner.
// The response sits in an output register, so a new request word is taken
// while an earlier response still waits. If the receiver stalls while a
// second response is ready, the scanner holds it and accepts nothing more.
// Reset returns every voice to released, idle and pitch zero at once through
// per-entry valid bits; no clearing pass is needed.
module polyphonic_voice_allocator #(
   parameter int VOICES = pva_pkg::DefaultVoices
) (
   input logic      clock,
   input logic      reset,
   pva_req_if.sink  req_chan,
   pva_rsp_if.source rsp_chan
);
   import pva_pkg::*;

   scan_status_type status;
   rsp_word_type    scan_word;
   req_word_type    req_word;
   logic            slot_free;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_word_type    rsp_word_ff, rsp_word_in;

   assign req_word.command = req_chan.command;
   assign req_word.pitch = req_chan.pitch;
   assign req_word.velocity = req_chan.velocity;
   assign req_word.done_voice = req_chan.done_voice;
   assign req_word.now = req_chan.now;
   assign req_chan.ready = status.ready;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   pva_voice_scan #(.VOICES(VOICES)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (req_chan.valid && status.ready),
      .req_word  (req_word),
      .slot_free (slot_free),
      .status    (status),
      .rsp_word  (scan_word)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      if (status.load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in = scan_word;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.assigned = rsp_word_ff.assigned;
   assign rsp_chan.voice = rsp_word_ff.voice;
   assign rsp_chan.level = rsp_word_ff.level;
   assign rsp_chan.released_mask = rsp_word_ff.released_mask;

endmodule

@@ hw/rtl/pva_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module pva_ram #(
   parameter int Width = 8,
   parameter int Depth = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pva_voice_scan.sv @@
// Voice table scanner: walks the voice RAM one entry per cycle and applies one event.
// Depends on pva_pkg and pva_ram.
module pva_voice_scan #(
   parameter int VOICES = pva_pkg::DefaultVoices
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  pva_pkg::req_word_type    req_word,
   input  logic                     slot_free,
   output pva_pkg::scan_status_type status,
   output pva_pkg::rsp_word_type    rsp_word
);
   import pva_pkg::*;

   localparam int VW = $clog2(VOICES);
   localparam int EW = $bits(voice_entry_type);
   localparam logic [VW-1:0] LastIdx = VW'(VOICES - 1);

   state_type       state_ff, state_in;
   logic [VW-1:0]   rd_idx_ff, rd_idx_in;
   logic            p_valid_ff, p_valid_in;
   logic [VW-1:0]   p_idx_ff, p_idx_in;
   req_word_type    item_ff, item_in;
   logic            locked_ff, locked_in;
   logic            found_ff, found_in;
   logic [VW-1:0]   pick_ff, pick_in;
   logic [31:0]     pick_time_ff, pick_time_in;
   logic [31:0]     oldest_ff, oldest_in;
   logic [7:0]      mask_ff, mask_in;
   logic [VOICES-1:0] valid_ff, valid_in;

   logic            wr_en;
   logic [VW-1:0]   wr_addr;
   voice_entry_type wr_entry;
   logic [EW-1:0]   rd_data;
   voice_entry_type entry;
   logic            note_on;

   pva_ram #(.Width(EW), .Depth(VOICES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_entry)),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign entry = valid_ff[p_idx_ff] ? voice_entry_type'(rd_data) : ResetEntry;
   assign note_on = (item_ff.command == CMD_NOTE_ON);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == LastIdx) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_COMMIT;
         ST_COMMIT, ST_HOLD: state_in = slot_free ? ST_IDLE : ST_HOLD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      status.ready = (state_ff == ST_IDLE);
      status.load = ((state_ff == ST_COMMIT) || (state_ff == ST_HOLD)) && slot_free;
      rsp_word.assigned = note_on && found_ff;
      rsp_word.voice = (note_on && found_ff) ? 3'(pick_ff) : 3'd0;
      rsp_word.level = (note_on && found_ff) ?
                       16'(16'(item_ff.velocity) * 16'(LevelScale)) : 16'd0;
      rsp_word.released_mask = mask_ff;
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      p_valid_in = (state_ff == ST_SCAN);
      p_idx_in = rd_idx_ff;
      item_in = item_ff;
      locked_in = locked_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      pick_time_in = pick_time_ff;
      oldest_in = oldest_ff;
      mask_in = mask_ff;
      valid_in = valid_ff;
      wr_en = 1'b0;
      wr_addr = p_idx_ff;
      wr_entry = entry;

      if (state_ff == ST_IDLE && start) begin
         item_in = req_word;
         rd_idx_in = '0;
         locked_in = 1'b0;
         found_in = 1'b0;
         pick_in = '0;
         oldest_in = TimeStart;
         mask_in = 8'd0;
      end else if (state_ff == ST_SCAN) begin
         rd_idx_in = rd_idx_ff + VW'(1);
      end

      if (p_valid_ff) begin
         unique case (cmd_type'(item_ff.command))
            CMD_NOTE_ON: begin
               if (!locked_ff && entry.released) begin
                  if (entry.env_idle) begin
                     pick_in = p_idx_ff;
                     pick_time_in = entry.rel_time;
                     found_in = 1'b1;
                     locked_in = 1'b1;
                  end else begin
                     if (entry.rel_time < oldest_ff) begin
                        oldest_in = entry.rel_time;
                        pick_in = p_idx_ff;
                        pick_time_in = entry.rel_time;
                        found_in = 1'b1;
                     end
                     if (entry.pitch == item_ff.pitch) begin
                        pick_in = p_idx_ff;
                        pick_time_in = entry.rel_time;
                        found_in = 1'b1;
                     end
                  end
               end
            end
            CMD_NOTE_OFF, CMD_ALL_OFF: begin
               if (item_ff.command == CMD_ALL_OFF || entry.pitch == item_ff.pitch) begin
                  wr_en = 1'b1;
                  wr_entry.released = 1'b1;
                  wr_entry.rel_time = item_ff.now;
                  mask_in = mask_ff | (8'd1 << p_idx_ff);
               end
            end
            CMD_VOICE_DONE: begin
               if (32'(p_idx_ff) == 32'(item_ff.done_voice)) begin
                  wr_en = 1'b1;
                  wr_entry.env_idle = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (state_ff == ST_COMMIT && note_on && found_ff) begin
         wr_en = 1'b1;
         wr_addr = pick_ff;
         wr_entry.released = 1'b0;
         wr_entry.rel_time = pick_time_ff;
         wr_entry.pitch = item_ff.pitch;
         wr_entry.env_idle = 1'b0;
      end

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p_valid_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         p_valid_ff <= p_valid_in;
         valid_ff <= valid_in;
      end
      rd_idx_ff <= rd_idx_in;
      p_idx_ff <= p_idx_in;
      item_ff <= item_in;
      locked_ff <= locked_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      pick_time_ff <= pick_time_in;
      oldest_ff <= oldest_in;
      mask_ff <= mask_in;
   end

endmodule
